>>> rtl/assert_macros.svh
// assertion macros shared by the checker files of the subleq machine
// no dependencies; take it in with a plain include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is high
`define SLQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define SLQ_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/slq_pkg.sv
// constants and field layout for the subleq machine with bit loader
// no dependencies; used by the top level and by its checker
`default_nettype none

package slq_pkg;

   // phase codes of the machine loop
   localparam logic [2:0] PH_HELLO  = 3'd0;
   localparam logic [2:0] PH_WORLD  = 3'd1;
   localparam logic [2:0] PH_BRANCH = 3'd2;
   localparam logic [2:0] PH_CONT   = 3'd3;
   localparam logic [2:0] PH_SUBLEQ = 3'd4;
   localparam logic [2:0] PH_HALT   = 3'd5;

   // request mode codes
   localparam logic [1:0] MODE_HELLO = 2'd0;
   localparam logic [1:0] MODE_WORLD = 2'd1;

   // instruction stride and the single toggled bit
   localparam int STRIDE  = 3;
   localparam int BIT_ONE = 8'h01;

   // request field layout
   localparam int MODE_W      = 2;
   localparam int CHAR_W      = 9;
   localparam int REQ_TDATA_W = 16;

   // response field layout
   localparam int OUT_VALID_BIT = 0;
   localparam int OUT_CHAR_LSB  = 1;
   localparam int OUT_CHAR_W    = 8;
   localparam int IN_TAKEN_BIT  = 9;
   localparam int HALTED_BIT    = 10;
   localparam int PC_LSB        = 11;
   localparam int PC_W          = 13;
   localparam int RSP_TDATA_W   = 24;

endpackage

`default_nettype wire

>>> rtl/slq_bitmod.sv
// bit cursor reduction: non-negative remainder of a signed word modulo WORD_BITS
// self-contained; one bit per cycle, or the registered low bits when WORD_BITS is a power of two
`default_nettype none

module slq_bitmod #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [WORD_BITS-1:0]          value,
   output logic                               done,
   output logic [$clog2(WORD_BITS)-1:0]       rem
);

   localparam int RW  = $clog2(WORD_BITS);
   localparam int RW1 = RW + 1;
   localparam int CW  = $clog2(WORD_BITS + 1);

   generate
      if ((WORD_BITS & (WORD_BITS - 1)) == 0) begin : g_pow2
         logic          done_ff;
         logic [RW-1:0] rem_ff;

         // low bits already are the remainder, two's complement included
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= value[RW-1:0];
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end else begin : g_serial
         localparam logic [RW:0] WB_C = RW1'(WORD_BITS);

         logic                 busy_ff;
         logic                 done_ff;
         logic [CW-1:0]        cnt_ff;
         logic [WORD_BITS-1:0] val_ff;
         logic [RW-1:0]        wt_ff;
         logic [RW-1:0]        acc_ff;
         logic [RW:0]          wt_eff;
         logic [RW:0]          acc_sum;
         logic [RW:0]          acc_red;
         logic [RW:0]          wt_dbl;
         logic [RW:0]          wt_red;

         // residue accumulation lsb first; the sign bit weighs minus its power of two
         assign wt_eff  = (cnt_ff != CW'(1)) ? {1'b0, wt_ff} :
                          ((wt_ff == '0) ? '0 : (WB_C - {1'b0, wt_ff}));
         assign acc_sum = {1'b0, acc_ff} + (val_ff[0] ? wt_eff : '0);
         assign acc_red = (acc_sum >= WB_C) ? (acc_sum - WB_C) : acc_sum;

         // weight of the next bit position, kept reduced
         assign wt_dbl  = {wt_ff, 1'b0};
         assign wt_red  = (wt_dbl >= WB_C) ? (wt_dbl - WB_C) : wt_dbl;

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
               end else if (busy_ff && (cnt_ff == CW'(1))) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               cnt_ff <= CW'(WORD_BITS);
               val_ff <= value;
               wt_ff  <= RW'(1);
               acc_ff <= '0;
            end else if (busy_ff) begin
               cnt_ff <= cnt_ff - CW'(1);
               val_ff <= {1'b0, val_ff[WORD_BITS-1:1]};
               wt_ff  <= wt_red[RW-1:0];
               acc_ff <= acc_red[RW-1:0];
            end
         end

         // accumulator already lies in the range
         assign done = done_ff;
         assign rem  = acc_ff;
      end
   endgenerate

endmodule

`default_nettype wire

>>> rtl/slq_wordmem.sv
// word store of the subleq machine: single port, registered read
// self-contained; cleared by the owner through ordinary writes
`default_nettype none

module slq_wordmem #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] word_mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one address per cycle, shared by the write and the read
   always_ff @(posedge clock) begin
      if (we) begin
         word_mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= word_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/subleq_machine_with_bit_loader.sv
// Top level of the subleq machine with bit loader; uses slq_pkg, slq_wordmem and slq_bitmod.
// Each request transfer runs one loop phase and gives exactly one response transfer. After reset
// the word store is cleared one word per cycle, with req_tready low. All work goes through the
// single port of the word store and one shared word adder. A world toggle holds one bit cursor
// reduction and a hello toggle two. MEM_WORDS is taken as a power of two. A new request is taken
// while the previous response still waits.
`default_nettype none

module subleq_machine_with_bit_loader #(
   parameter int MEM_WORDS = 8192,
   parameter int WORD_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: mode [1:0], in_char [10:2], zero [15:11]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [slq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // rsp_tdata: out_valid [0], out_char [8:1], in_taken [9], is_halted [10], pc_now [23:11]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [slq_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   import slq_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);
   localparam int RW = $clog2(WORD_BITS);

   // sequencer states
   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_FA    = 5'd2;
   localparam logic [4:0] S_FB    = 5'd3;
   localparam logic [4:0] S_FC    = 5'd4;
   localparam logic [4:0] S_DEC   = 5'd5;
   localparam logic [4:0] S_RA    = 5'd6;
   localparam logic [4:0] S_RA_W  = 5'd7;
   localparam logic [4:0] S_RB    = 5'd8;
   localparam logic [4:0] S_RB_W  = 5'd9;
   localparam logic [4:0] S_MOD1  = 5'd10;
   localparam logic [4:0] S_RX    = 5'd11;
   localparam logic [4:0] S_RX_W  = 5'd12;
   localparam logic [4:0] S_WX    = 5'd13;
   localparam logic [4:0] S_MOD2  = 5'd14;
   localparam logic [4:0] S_RB2   = 5'd15;
   localparam logic [4:0] S_RB2_W = 5'd16;
   localparam logic [4:0] S_WB2   = 5'd17;
   localparam logic [4:0] S_SQ    = 5'd18;
   localparam logic [4:0] S_RESP  = 5'd19;

   // control state
   logic [4:0]    state_ff, state_in;
   logic [2:0]    phase_ff, phase_in;
   logic [AW-1:0] ip_ff, ip_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working words
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] c_ff, c_in;
   logic [WORD_BITS-1:0] ad_ff, ad_in;
   logic [WORD_BITS-1:0] bd_ff, bd_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] mask_ff, mask_in;
   logic [WORD_BITS-1:0] na_ff, na_in;
   logic [WORD_BITS-1:0] in_word_ff, in_word_in;
   logic                 one_ff, one_in;

   // per-step results and the response register
   logic                      out_valid_ff, out_valid_in;
   logic [OUT_CHAR_W-1:0]     out_char_ff, out_char_in;
   logic                      took_ff, took_in;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // store port
   logic                 mem_we;
   logic                 mem_re;
   logic [AW-1:0]        mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] mem_rdata;

   // read and write helpers that route negative addresses to the character port
   logic                 rd_req;
   logic [WORD_BITS-1:0] rd_tgt;
   logic                 wr_req;
   logic [WORD_BITS-1:0] wr_tgt;
   logic [WORD_BITS-1:0] wr_val;

   // shared word adder
   logic [WORD_BITS-1:0] alu_x;
   logic [WORD_BITS-1:0] alu_y;
   logic [WORD_BITS-1:0] alu_sum;

   // bit cursor reduction
   logic                 mod_start;
   logic [WORD_BITS-1:0] mod_value;
   logic                 mod_done;
   logic [RW-1:0]        mod_rem;
   logic [WORD_BITS-1:0] mod_word;

   // field views
   logic [MODE_W-1:0]           req_mode;
   logic [WORD_BITS+CHAR_W-1:0] char_ext;
   logic [PC_W+AW-1:0]          pc_ext;
   logic [WORD_BITS-1:0]        tog_word;
   logic                        tog_one;
   logic                        is_sq;

   function automatic logic is_neg(input logic [WORD_BITS-1:0] w);
      return w[WORD_BITS-1];
   endfunction

   // address of a non-negative word, wrapped to the store size
   function automatic logic [AW-1:0] addr_of(input logic [WORD_BITS-1:0] w);
      logic [AW+WORD_BITS-1:0] ext;
      ext = {{AW{1'b0}}, w};
      return ext[AW-1:0];
   endfunction

   assign req_mode = req_tdata[MODE_W-1:0];
   assign char_ext = {{WORD_BITS{req_tdata[MODE_W+CHAR_W-1]}}, req_tdata[MODE_W +: CHAR_W]};
   assign pc_ext   = {{PC_W{1'b0}}, ip_ff};
   assign tog_word = mask_ff ^ x_ff;
   assign tog_one  = |(mask_ff & tog_word);
   assign mod_word = {{(WORD_BITS-RW){1'b0}}, mod_rem};
   assign is_sq    = (phase_ff == PH_SUBLEQ);

   // operand selection for the shared adder
   always_comb begin
      alu_x = ad_ff;
      alu_y = '0;
      case (state_ff)
         S_WB2:   alu_x = x_ff;
         S_SQ: begin
            alu_x = bd_ff;
            alu_y = ~ad_ff;
         end
         default: alu_x = ad_ff;
      endcase
   end

   // plus one always enters as carry: increments, and negation of the subtrahend
   assign alu_sum = alu_x + alu_y + {{(WORD_BITS-1){1'b0}}, 1'b1};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      ip_in        = ip_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      ad_in        = ad_ff;
      bd_in        = bd_ff;
      x_in         = x_ff;
      mask_in      = mask_ff;
      na_in        = na_ff;
      in_word_in   = in_word_ff;
      one_in       = one_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      took_in      = took_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = ip_ff;
      mem_wdata    = '0;
      rd_req       = 1'b0;
      rd_tgt       = a_ff;
      wr_req       = 1'b0;
      wr_tgt       = b_ff;
      wr_val       = alu_sum;
      mod_start    = 1'b0;
      mod_value    = ad_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               in_word_in   = char_ext[WORD_BITS-1:0];
               out_valid_in = 1'b0;
               out_char_in  = '0;
               took_in      = 1'b0;
               state_in     = S_FA;
               if (phase_ff == PH_HALT) begin
                  if (req_mode == MODE_HELLO) begin
                     phase_in = PH_HELLO;
                  end else if (req_mode == MODE_WORLD) begin
                     phase_in = PH_WORLD;
                  end else begin
                     state_in = S_RESP;
                  end
               end
            end
         end
         // operand fetch at ip, ip+1, ip+2
         S_FA: begin
            mem_re   = 1'b1;
            mem_addr = ip_ff;
            state_in = S_FB;
         end
         S_FB: begin
            a_in     = mem_rdata;
            mem_re   = 1'b1;
            mem_addr = ip_ff + AW'(1);
            state_in = S_FC;
         end
         S_FC: begin
            b_in     = mem_rdata;
            mem_re   = 1'b1;
            mem_addr = ip_ff + AW'(2);
            state_in = S_DEC;
         end
         S_DEC: begin
            c_in = mem_rdata;
            unique case (phase_ff) inside
               PH_HELLO, PH_WORLD, PH_SUBLEQ: begin
                  state_in = S_RA;
               end
               PH_BRANCH: begin
                  if (is_neg(mem_rdata)) begin
                     ip_in    = ip_ff + AW'(STRIDE);
                     phase_in = PH_SUBLEQ;
                  end else begin
                     ip_in    = addr_of(mem_rdata);
                     phase_in = PH_HALT;
                  end
                  state_in = S_RESP;
               end
               PH_CONT: begin
                  ip_in    = ip_ff + AW'(STRIDE);
                  phase_in = PH_HALT;
                  state_in = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         // value at a
         S_RA: begin
            rd_req = 1'b1;
            rd_tgt = a_ff;
            if (is_neg(a_ff)) begin
               ad_in    = in_word_ff;
               state_in = S_RB;
            end else begin
               state_in = S_RA_W;
            end
         end
         S_RA_W: begin
            ad_in    = mem_rdata;
            state_in = S_RB;
         end
         // value at b; subleq reads a negative b as zero without taking the character
         S_RB: begin
            if (is_neg(b_ff)) begin
               bd_in   = is_sq ? '0 : in_word_ff;
               took_in = took_ff | !is_sq;
               if (is_sq) begin
                  state_in = S_SQ;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MOD1;
               end
            end else begin
               mem_re   = 1'b1;
               mem_addr = addr_of(b_ff);
               state_in = S_RB_W;
            end
         end
         S_RB_W: begin
            bd_in = mem_rdata;
            if (is_sq) begin
               state_in = S_SQ;
            end else begin
               mod_start = 1'b1;
               state_in  = S_MOD1;
            end
         end
         // toggle mask from the bit cursor
         S_MOD1: begin
            if (mod_done) begin
               mask_in  = WORD_BITS'(BIT_ONE) << mod_rem;
               state_in = S_RX;
            end
         end
         // word pointed to by the value at b
         S_RX: begin
            rd_req = 1'b1;
            rd_tgt = bd_ff;
            if (is_neg(bd_ff)) begin
               x_in     = in_word_ff;
               state_in = S_WX;
            end else begin
               state_in = S_RX_W;
            end
         end
         S_RX_W: begin
            x_in     = mem_rdata;
            state_in = S_WX;
         end
         // write the toggled word back
         S_WX: begin
            wr_req = 1'b1;
            wr_tgt = bd_ff;
            wr_val = tog_word;
            if (phase_ff == PH_HELLO) begin
               one_in    = tog_one;
               na_in     = alu_sum;
               mod_start = 1'b1;
               mod_value = alu_sum;
               state_in  = S_MOD2;
            end else begin
               phase_in = tog_one ? PH_CONT : PH_BRANCH;
               state_in = S_RESP;
            end
         end
         // store the wrapped cursor, carry into the pointer when it wrapped
         S_MOD2: begin
            if (mod_done) begin
               wr_req = 1'b1;
               wr_tgt = a_ff;
               wr_val = mod_word;
               if (na_ff != mod_word) begin
                  state_in = S_RB2;
               end else begin
                  phase_in = one_ff ? PH_BRANCH : PH_CONT;
                  state_in = S_RESP;
               end
            end
         end
         S_RB2: begin
            rd_req = 1'b1;
            rd_tgt = b_ff;
            if (is_neg(b_ff)) begin
               x_in     = in_word_ff;
               state_in = S_WB2;
            end else begin
               state_in = S_RB2_W;
            end
         end
         S_RB2_W: begin
            x_in     = mem_rdata;
            state_in = S_WB2;
         end
         S_WB2: begin
            wr_req   = 1'b1;
            wr_tgt   = b_ff;
            wr_val   = alu_sum;
            phase_in = one_ff ? PH_BRANCH : PH_CONT;
            state_in = S_RESP;
         end
         // subleq: b minus a, branch on not positive
         S_SQ: begin
            wr_req = 1'b1;
            wr_tgt = b_ff;
            wr_val = alu_sum;
            if (is_neg(alu_sum) || (alu_sum == '0)) begin
               if (is_neg(c_ff)) begin
                  ip_in    = ip_ff + AW'(STRIDE);
                  phase_in = PH_HALT;
               end else begin
                  ip_in = addr_of(c_ff);
               end
            end else begin
               ip_in = ip_ff + AW'(STRIDE);
            end
            state_in = S_RESP;
         end
         // hand the result to the response register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pc_ext[PC_W-1:0], (phase_ff == PH_HALT), took_ff,
                               out_char_ff, out_valid_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // reads: negative address takes the character
      if (rd_req) begin
         if (is_neg(rd_tgt)) begin
            took_in = 1'b1;
         end else begin
            mem_re   = 1'b1;
            mem_addr = addr_of(rd_tgt);
         end
      end

      // writes: negative address emits the low byte
      if (wr_req) begin
         if (is_neg(wr_tgt)) begin
            out_valid_in = 1'b1;
            out_char_in  = wr_val[OUT_CHAR_W-1:0];
         end else begin
            mem_we    = 1'b1;
            mem_addr  = addr_of(wr_tgt);
            mem_wdata = wr_val;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_HALT;
         ip_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ip_ff        <= ip_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      ad_ff        <= ad_in;
      bd_ff        <= bd_in;
      x_ff         <= x_in;
      mask_ff      <= mask_in;
      na_ff        <= na_in;
      in_word_ff   <= in_word_in;
      one_ff       <= one_in;
      out_valid_ff <= out_valid_in;
      out_char_ff  <= out_char_in;
      took_ff      <= took_in;
      rsp_data_ff  <= rsp_data_in;
   end

   slq_wordmem #(
      .DEPTH (MEM_WORDS),
      .WIDTH (WORD_BITS)
   ) u_wordmem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   slq_bitmod #(
      .WORD_BITS (WORD_BITS)
   ) u_bitmod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (mod_value),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/slq_checker.sv
// port-level checks for the subleq machine, bound to the top level below
// depends on slq_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module slq_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [slq_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   import slq_pkg::*;

   // store clearing keeps both channels quiet right after reset
   `SLQ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> (!req_tready && !rsp_tvalid), "busy after reset expected")

   // a request transfer always takes the machine out of the ready state
   `SLQ_ASSERT(a_busy_after_req, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "ready right after a request transfer")

   // no output write means a zero character
   `SLQ_ASSERT(a_char_zero, clock, reset, (rsp_tvalid && !rsp_tdata[OUT_VALID_BIT]) |-> (rsp_tdata[OUT_CHAR_LSB +: OUT_CHAR_W] == '0), "character without output write")

   // a waiting response stays put
   `SLQ_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "response changed while stalled")

endmodule

bind subleq_machine_with_bit_loader slq_checker u_slq_checker (.*);

`default_nettype wire

>>> dv/subleq_machine_with_bit_loader_test.sv
// self-checking testbench for subleq_machine_with_bit_loader: request transfers drive an
// in-bench model of the word machine and every response is compared with it field by field
// depends on slq_pkg and the top-level rtl of the machine
module subleq_machine_with_bit_loader_test;
   timeunit 1ns;
   timeprecision 1ps;

   import slq_pkg::*;

   localparam int MEM_WORDS   = 8192;
   localparam int WORD_BITS   = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RUN_CAP     = 48;
   localparam int PLAN_TRIES  = 6;
   localparam int SETTLE      = 64;

   // advance code, and the spare code that also behaves as advance
   localparam logic [1:0] MODE_STEP  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef bit [WORD_BITS-1:0] word_type;

   typedef struct packed {
      bit                  out_valid;
      bit [OUT_CHAR_W-1:0] out_char;
      bit                  in_taken;
      bit                  is_halted;
      bit [PC_W-1:0]       pc_now;
   } step_out_type;

   typedef struct packed {
      bit [31:0] addr;
      word_type  old;
   } undo_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // model of the machine state
   word_type    word_image [MEM_WORDS];
   int unsigned instr_at  = 0;
   bit [2:0]    phase_now = PH_HALT;

   // port activity within one step
   bit          port_wrote;
   bit          port_read;
   bit [7:0]    port_byte;
   word_type    port_in;

   // lookahead of a run before it is sent
   bit          trial_on;
   undo_type    undo_log [$];
   bit [1:0]    run_mode;
   bit [8:0]    run_chars [$];

   step_out_type step_outputs_q [$];
   bit           idle_on;
   int           fail_count;
   int           rsp_count;
   int           cycle_count;

   subleq_machine_with_bit_loader #(
      .MEM_WORDS (MEM_WORDS),
      .WORD_BITS (WORD_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // read through an address word: negative addresses give the input character
   function automatic word_type fetch_word(word_type w);
      if (w[WORD_BITS-1]) begin
         port_read = 1'b1;
         return port_in;
      end
      return word_image[w % MEM_WORDS];
   endfunction

   // write through an address word: negative addresses go to the output port
   function automatic void store_word(word_type w, word_type v);
      int unsigned idx;
      undo_type    u;
      if (w[WORD_BITS-1]) begin
         port_wrote = 1'b1;
         port_byte  = v[7:0];
      end else begin
         idx = w % MEM_WORDS;
         if (trial_on) begin
            u.addr = idx;
            u.old  = word_image[idx];
            undo_log.push_back(u);
         end
         word_image[idx] = v;
      end
   endfunction

   // bit number of a cursor word, non-negative remainder for negative cursors
   function automatic int unsigned cursor_of(word_type w);
      word_type    m;
      int unsigned r;
      if (!w[WORD_BITS-1]) return w % WORD_BITS;
      m = -w;
      r = m % WORD_BITS;
      return (r != 0) ? WORD_BITS - r : 0;
   endfunction

   function automatic void skip_ahead();
      instr_at = (instr_at + STRIDE) % MEM_WORDS;
   endfunction

   // hello and world: toggle the cursor bit of the target word, hello also moves the cursor
   function automatic void toggle_bit(word_type a, word_type b, bit hello);
      word_type ad, bd, mask, nb, na, md;
      bit       one;
      ad   = fetch_word(a);
      bd   = fetch_word(b);
      mask = word_type'(BIT_ONE) << cursor_of(ad);
      nb   = mask ^ fetch_word(bd);
      one  = |(mask & nb);
      store_word(bd, nb);
      if (hello) begin
         na = ad + 1'b1;
         md = word_type'(cursor_of(na));
         store_word(a, md);
         // cursor wrapped, carry into the pointer
         if (na != md) store_word(b, fetch_word(b) + 1'b1);
         phase_now = one ? PH_BRANCH : PH_CONT;
      end else begin
         phase_now = one ? PH_CONT : PH_BRANCH;
      end
   endfunction

   // one subleq instruction; a negative b reads as zero without taking the input
   function automatic void run_subleq(word_type a, word_type b, word_type c);
      word_type ad, bd, nb;
      ad = fetch_word(a);
      bd = b[WORD_BITS-1] ? '0 : word_image[b % MEM_WORDS];
      nb = bd - ad;
      store_word(b, nb);
      if (nb[WORD_BITS-1] || nb == '0) begin
         if (c[WORD_BITS-1]) begin
            skip_ahead();
            phase_now = PH_HALT;
         end else begin
            instr_at = c % MEM_WORDS;
         end
      end else begin
         skip_ahead();
      end
   endfunction

   // one loop phase of the machine for one request
   function automatic step_out_type machine_phase(bit [1:0] mode, bit [8:0] ch);
      word_type     a, b, c;
      step_out_type o;
      port_in    = {{(WORD_BITS-9){ch[8]}}, ch};
      port_wrote = 1'b0;
      port_read  = 1'b0;
      port_byte  = '0;
      a = word_image[instr_at];
      b = word_image[(instr_at + 1) % MEM_WORDS];
      c = word_image[(instr_at + 2) % MEM_WORDS];
      // a start code only counts while halted
      if (phase_now > PH_SUBLEQ) begin
         phase_now = PH_HALT;
         if (mode == MODE_HELLO) phase_now = PH_HELLO;
         else if (mode == MODE_WORLD) phase_now = PH_WORLD;
      end
      case (phase_now)
         PH_HELLO: toggle_bit(a, b, 1'b1);
         PH_WORLD: toggle_bit(a, b, 1'b0);
         PH_BRANCH: begin
            if (c[WORD_BITS-1]) begin
               skip_ahead();
               phase_now = PH_SUBLEQ;
            end else begin
               instr_at  = c % MEM_WORDS;
               phase_now = PH_HALT;
            end
         end
         PH_CONT: begin
            skip_ahead();
            phase_now = PH_HALT;
         end
         PH_SUBLEQ: run_subleq(a, b, c);
         default: ;
      endcase
      o.out_valid = port_wrote;
      o.out_char  = port_byte;
      o.in_taken  = port_read;
      o.is_halted = (phase_now == PH_HALT);
      o.pc_now    = instr_at[PC_W-1:0];
      return o;
   endfunction

   // input character, weighted towards end of input and the sign boundary
   function automatic bit [8:0] pick_char();
      bit [8:0] v;
      v = $urandom_range(0, 511);
      case ($urandom_range(0, 15))
         0, 1: v = 9'h1FF;
         2: v = 9'h100;
         3: v = 9'h0FF;
         4: v = 9'h000;
         default: ;
      endcase
      return v;
   endfunction

   // any code acts as advance while running
   function automatic bit [1:0] pick_running_mode();
      bit [1:0] m;
      m = $urandom_range(0, 3);
      return ($urandom_range(0, 3) == 0) ? m : MODE_STEP;
   endfunction

   // try up to PLAN_TRIES starts and characters for a run that halts within RUN_CAP steps
   function automatic void plan_run();
      step_out_type o;
      undo_type     u;
      int unsigned  saved_at;
      bit [2:0]     saved_phase;
      int           tries;
      for (tries = 0; tries < PLAN_TRIES; tries++) begin
         run_mode = $urandom_range(0, 1) ? MODE_WORLD : MODE_HELLO;
         run_chars.delete();
         undo_log.delete();
         saved_at    = instr_at;
         saved_phase = phase_now;
         trial_on    = 1'b1;
         do begin
            run_chars.push_back(pick_char());
            o = machine_phase((run_chars.size() == 1) ? run_mode : MODE_STEP,
                              run_chars[run_chars.size()-1]);
         end while (!o.is_halted && run_chars.size() < RUN_CAP);
         // wind the trial back
         while (undo_log.size() != 0) begin
            u = undo_log.pop_back();
            word_image[u.addr] = u.old;
         end
         instr_at  = saved_at;
         phase_now = saved_phase;
         trial_on  = 1'b0;
         if (o.is_halted) return;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in response %0d: %s got 0x%0h, expected 0x%0h",
               rsp_count, what, got, want);
      fail_count++;
   endtask

   // one request transfer; the expected response is queued once it is taken
   task automatic send_op(input bit [1:0] mode, input bit [8:0] ch);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tdata  <= {{(REQ_TDATA_W-MODE_W-CHAR_W){1'b0}}, ch, mode};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      step_outputs_q.push_back(machine_phase(mode, ch));
   endtask

   task automatic send_planned_run();
      int i;
      plan_run();
      for (i = 0; i < run_chars.size(); i++)
         send_op((i == 0) ? run_mode : pick_running_mode(), run_chars[i]);
   endtask

   // a start followed by up to three advances given as the other codes
   task automatic start_and_follow(input bit [1:0] mode, input bit [8:0] ch);
      int n;
      send_op(mode, ch);
      for (n = 0; n < 3 && phase_now != PH_HALT; n++)
         send_op((n == 0) ? MODE_HELLO : (n == 1) ? MODE_WORLD : MODE_SPARE, ~ch);
   endtask

   // advance and spare code while halted, input character extremes
   task automatic test_halted_inputs();
      send_op(MODE_STEP, 9'h000);
      send_op(MODE_STEP, 9'h1FF);
      send_op(MODE_SPARE, 9'h0FF);
      send_op(MODE_SPARE, 9'h100);
   endtask

   // first hello and world operations out of the cleared store
   task automatic test_bootstrap_ops();
      start_and_follow(MODE_HELLO, 9'h1FF);
      start_and_follow(MODE_WORLD, 9'h100);
      start_and_follow(MODE_HELLO, 9'h0FF);
      start_and_follow(MODE_HELLO, 9'h000);
      start_and_follow(MODE_WORLD, 9'h155);
   endtask

   // mostly complete runs with random content, some ignored codes while halted
   task automatic test_random_programs(input int target);
      int       sent;
      bit [1:0] mode;
      sent = 0;
      while (sent < target) begin
         if (phase_now != PH_HALT) begin
            send_op(pick_running_mode(), pick_char());
            sent++;
         end else if ($urandom_range(0, 9) == 0) begin
            mode = $urandom_range(0, 1) ? MODE_SPARE : MODE_STEP;
            send_op(mode, pick_char());
         end else begin
            send_planned_run();
            sent += run_chars.size();
         end
      end
   endtask

   // sender holds off until every response is back, then starts again
   task automatic test_drained_restart();
      repeat (3) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (step_outputs_q.size() != 0);
         if (phase_now == PH_HALT) send_planned_run();
         else send_op(MODE_STEP, pick_char());
      end
   endtask

   // stimulus sequence
   initial begin : main_seq
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_halted_inputs();
      test_bootstrap_ops();
      idle_on <= 1'b1;
      test_random_programs(350);
      test_drained_restart();
      idle_on <= 1'b0;
      test_random_programs(150);
      idle_on <= 1'b1;
      test_random_programs(350);
      idle_on <= 1'b0;
      test_random_programs(150);
      req_tvalid <= 1'b0;
      while (step_outputs_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // response side ready, with stall bursts while idling is on
   initial begin : rsp_ready_drive
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (idle_on) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
      end
   end

   // compare each response transfer with the oldest expectation
   initial begin : rsp_check
      step_out_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (step_outputs_q.size() == 0) begin
               report_mismatch("response with no request pending", rsp_tdata, '0);
            end else begin
               want = step_outputs_q.pop_front();
               if (rsp_tdata[OUT_VALID_BIT] !== want.out_valid)
                  report_mismatch("out_valid", rsp_tdata[OUT_VALID_BIT], want.out_valid);
               if (rsp_tdata[OUT_CHAR_LSB +: OUT_CHAR_W] !== want.out_char)
                  report_mismatch("out_char", rsp_tdata[OUT_CHAR_LSB +: OUT_CHAR_W],
                                  want.out_char);
               if (rsp_tdata[IN_TAKEN_BIT] !== want.in_taken)
                  report_mismatch("in_taken", rsp_tdata[IN_TAKEN_BIT], want.in_taken);
               if (rsp_tdata[HALTED_BIT] !== want.is_halted)
                  report_mismatch("is_halted", rsp_tdata[HALTED_BIT], want.is_halted);
               if (rsp_tdata[PC_LSB +: PC_W] !== want.pc_now)
                  report_mismatch("pc_now", rsp_tdata[PC_LSB +: PC_W], want.pc_now);
            end
         end
      end
   end

   // run time limit, store clearing after reset included
   initial begin : watchdog
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

endmodule

>>> subleq_machine_with_bit_loader.f
+incdir+rtl
rtl/slq_pkg.sv
rtl/slq_bitmod.sv
rtl/slq_wordmem.sv
rtl/subleq_machine_with_bit_loader.sv
rtl/slq_checker.sv
dv/subleq_machine_with_bit_loader_test.sv
